/* hdl/spd_pkg.sv */
package spd_pkg;

   localparam int unsigned MAX_PATTERN_DEFAULT = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } spd_cmd_type;

   typedef struct packed {
      logic pat_clear;
      logic pat_shift;
      logic txt_clear;
      logic txt_step;
   } spd_ctrl_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pat_byte;
      logic              pat_act;
      logic [BYTE_W-1:0] txt_byte;
      logic              txt_act;
   } spd_link_type;

endpackage

/* hdl/substring_presence_detector_unit.sv */
// Result: registered, so it appears on rsp in the cycle after the transaction that ends a text.
// Throughput: one req transaction per cycle unless a held result stalls req_tready;
// every cell of the chain compares its alignment in the same cycle the text byte is taken.
// Reset: synchronous, active high; clears pattern, text window and pending result.
module substring_presence_detector_unit #(
   parameter int unsigned MAX_PATTERN = spd_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [spd_pkg::BYTE_W-1:0]       req_tdata,  // [7:0] data_byte
   input  logic [spd_pkg::CMD_W-1:0]        req_tuser,  // [1:0] cmd
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [spd_pkg::RSP_DATA_W-1:0]   rsp_tdata   // [0] found, [1] pattern_overflow
);
   import spd_pkg::*;

   spd_cmd_type  cmd;
   spd_ctrl_type ctrl;
   logic         accept;
   logic         full;
   logic         hit;
   logic         finish;
   logic         seen_now;

   logic ovf_ff, ovf_in;
   logic seen_ff, seen_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   assign cmd        = spd_cmd_type'(req_tuser);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ctrl.pat_clear = accept && (cmd == CMD_CLEAR);
      ctrl.pat_shift = accept && (cmd == CMD_APPEND) && !full;
      ctrl.txt_step  = accept && (cmd == CMD_TEXT);
      ctrl.txt_clear = accept && ((cmd != CMD_TEXT) || req_tlast);
   end

   spd_chain #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .data_byte (req_tdata),
      .full      (full),
      .hit       (hit)
   );

   assign finish   = accept && ((cmd == CMD_END) || ((cmd == CMD_TEXT) && req_tlast));
   assign seen_now = seen_ff || ((cmd == CMD_TEXT) && hit);

   always_comb begin
      seen_in = seen_ff;
      if (ctrl.txt_clear) begin
         seen_in = 1'b0;
      end else if (ctrl.txt_step) begin
         seen_in = seen_now;
      end

      ovf_in = ovf_ff;
      if (ctrl.pat_clear) begin
         ovf_in = 1'b0;
      end else if (accept && (cmd == CMD_APPEND) && full) begin
         ovf_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = !ovf_ff && seen_now;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, rsp_ovf_ff, rsp_found_ff};

endmodule

/* hdl/spd_cell.sv */
module spd_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  spd_pkg::spd_ctrl_type ctrl,
   input  spd_pkg::spd_link_type link_in,
   output spd_pkg::spd_link_type link_out,
   output logic                 ok
);
   import spd_pkg::*;

   logic [BYTE_W-1:0] pat_byte_ff, pat_byte_in;
   logic              pat_act_ff, pat_act_in;
   logic [BYTE_W-1:0] txt_byte_ff, txt_byte_in;
   logic              txt_act_ff, txt_act_in;

   always_comb begin
      pat_byte_in = ctrl.pat_shift ? link_in.pat_byte : pat_byte_ff;
      txt_byte_in = ctrl.txt_step ? link_in.txt_byte : txt_byte_ff;

      pat_act_in = pat_act_ff;
      if (ctrl.pat_clear) begin
         pat_act_in = 1'b0;
      end else if (ctrl.pat_shift) begin
         pat_act_in = link_in.pat_act;
      end

      txt_act_in = txt_act_ff;
      if (ctrl.txt_clear) begin
         txt_act_in = 1'b0;
      end else if (ctrl.txt_step) begin
         txt_act_in = link_in.txt_act;
      end
   end

   // compare against the window as it stands after this text byte
   assign ok = !pat_act_ff || (link_in.txt_act && (link_in.txt_byte == pat_byte_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_act_ff <= 1'b0;
         txt_act_ff <= 1'b0;
      end else begin
         pat_act_ff <= pat_act_in;
         txt_act_ff <= txt_act_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_byte_ff <= pat_byte_in;
      txt_byte_ff <= txt_byte_in;
   end

   assign link_out.pat_byte = pat_byte_ff;
   assign link_out.pat_act  = pat_act_ff;
   assign link_out.txt_byte = txt_byte_ff;
   assign link_out.txt_act  = txt_act_ff;

endmodule

/* hdl/spd_chain.sv */
module spd_chain #(
   parameter int unsigned MAX_PATTERN = spd_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spd_pkg::spd_ctrl_type       ctrl,
   input  logic [spd_pkg::BYTE_W-1:0]  data_byte,
   output logic                        full,
   output logic                        hit
);
   import spd_pkg::*;

   spd_link_type             links [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]   ok_vec;

   assign links[0].pat_byte = data_byte;
   assign links[0].pat_act  = 1'b1;
   assign links[0].txt_byte = data_byte;
   assign links[0].txt_act  = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      spd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .link_in  (links[k]),
         .link_out (links[k+1]),
         .ok       (ok_vec[k])
      );
   end

   assign full = links[MAX_PATTERN].pat_act;
   assign hit  = &ok_vec;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import spd_pkg::*;

   localparam int unsigned PAT_CAP = MAX_PATTERN_DEFAULT;
   localparam logic [BYTE_W-1:0] SEPARATOR = 8'h25;
   localparam int HOLD_CYCLES = 200;
   localparam int ITEMS_PER_PHASE = 312;

   typedef struct packed {
      spd_cmd_type       cmd;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } req_item_type;

   typedef struct packed {
      logic pattern_overflow;
      logic found;
   } text_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;   // [7:0] data_byte
   logic [CMD_W-1:0]      req_tuser = '0;   // [1:0] cmd
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [0] found, [1] pattern_overflow

   substring_presence_detector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [BYTE_W-1:0] pat_mem [PAT_CAP];
   logic [4:0]        pat_len = '0;
   logic              pat_ovf = 1'b0;
   logic [BYTE_W-1:0] win [PAT_CAP];
   logic [4:0]        txt_cnt = '0;
   logic              hit_seen = 1'b0;

   req_item_type    req_queue [$];
   text_result_type text_result_q [$];
   req_item_type    next_item;
   text_result_type want, got;
   logic            req_taken = 1'b0;
   logic            rsp_hold = 1'b0;
   logic            hold_go = 1'b0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              mismatch_count = 0;
   int              items_made = 0;

   // generator's view of the loaded pattern
   logic [BYTE_W-1:0] gen_pat [$];
   logic [BYTE_W-1:0] alph_base = 8'h00;
   int                alph_n = 2;

   function automatic text_result_type close_text();
      text_result_type r;
      r.pattern_overflow = pat_ovf;
      if (pat_ovf) r.found = 1'b0;
      else if (pat_len == 0) r.found = (txt_cnt != 0);
      else r.found = hit_seen;
      txt_cnt = '0;
      hit_seen = 1'b0;
      return r;
   endfunction

   function automatic logic predict_transaction(input req_item_type it,
                                                output text_result_type res);
      logic hit;
      int   k;
      predict_transaction = 1'b0;
      res = '0;
      case (it.cmd)
         CMD_CLEAR: begin
            pat_len = '0;
            pat_ovf = 1'b0;
            txt_cnt = '0;
            hit_seen = 1'b0;
         end
         CMD_APPEND: begin
            txt_cnt = '0;
            hit_seen = 1'b0;
            if (pat_len < PAT_CAP) begin
               pat_mem[pat_len] = it.data_byte;
               pat_len = pat_len + 1'b1;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         CMD_TEXT: begin
            for (k = PAT_CAP - 1; k > 0; k--) win[k] = win[k-1];
            win[0] = it.data_byte;
            if (txt_cnt < PAT_CAP) txt_cnt = txt_cnt + 1'b1;
            hit = (pat_len != 0) && (txt_cnt >= pat_len);
            for (k = 0; k < PAT_CAP; k++)
               if (k < pat_len && win[k] != pat_mem[pat_len - 1 - k]) hit = 1'b0;
            if (hit) hit_seen = 1'b1;
            if (it.last) begin
               res = close_text();
               predict_transaction = 1'b1;
            end
         end
         default: begin
            res = close_text();
            predict_transaction = 1'b1;
         end
      endcase
   endfunction

   task automatic add_item(input spd_cmd_type c, input logic [BYTE_W-1:0] d, input logic l);
      req_item_type it;
      it.cmd = c;
      it.data_byte = d;
      it.last = l;
      req_queue = {req_queue, it};
      items_made++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_symbol();
      if ($urandom_range(19) == 0) return BYTE_W'($urandom_range(255));
      return alph_base + BYTE_W'($urandom_range(alph_n - 1));
   endfunction

   task automatic build_random_traffic(input int n_items);
      int                start, r, len, tlen, pos, j, k, mode;
      logic              embed, sep;
      logic [1:0]        c;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] txt [$];
      start = items_made;
      while (items_made - start < n_items) begin
         r = $urandom_range(99);
         if (r < 8) begin
            // noise
            c = 2'($urandom_range(3));
            b = BYTE_W'($urandom_range(255));
            add_item(spd_cmd_type'(c), b, 1'($urandom_range(1)));
            if (spd_cmd_type'(c) == CMD_CLEAR) gen_pat.delete();
            else if (spd_cmd_type'(c) == CMD_APPEND && gen_pat.size() < PAT_CAP)
               gen_pat = {gen_pat, b};
         end else if (r < 25) begin
            add_item(CMD_CLEAR, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            gen_pat.delete();
            r = $urandom_range(9);
            if (r < 6) len = $urandom_range(4);
            else if (r < 8) len = $urandom_range(16, 5);
            else if (r == 8) len = PAT_CAP;
            else len = $urandom_range(20, 17);
            alph_base = BYTE_W'($urandom_range(255));
            alph_n = $urandom_range(3, 1);
            for (j = 0; j < len; j++) begin
               b = pick_symbol();
               add_item(CMD_APPEND, b, 1'($urandom_range(1)));
               if (gen_pat.size() < PAT_CAP) gen_pat = {gen_pat, b};
            end
         end else begin
            txt.delete();
            tlen = $urandom_range(20);
            embed = (gen_pat.size() != 0) && ($urandom_range(1) == 1);
            sep = ($urandom_range(1) == 1);
            pos = $urandom_range(tlen);
            for (j = 0; j <= tlen; j++) begin
               if (embed && j == pos) begin
                  for (k = 0; k < gen_pat.size(); k++) txt = {txt, gen_pat[k]};
                  if (sep) txt = {txt, SEPARATOR};
               end
               if (j < tlen) txt = {txt, pick_symbol()};
            end
            mode = $urandom_range(99);
            if (txt.size() == 0) begin
               add_item(CMD_END, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
               for (k = 0; k < txt.size(); k++)
                  add_item(CMD_TEXT, txt[k], (mode < 70) && (k == txt.size() - 1));
               if (mode >= 70 && mode < 90) begin
                  add_item(CMD_END, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
               end else if (mode >= 90) begin
                  // abandon the text with a pattern command
                  if ($urandom_range(1) == 1) begin
                     add_item(CMD_CLEAR, BYTE_W'($urandom_range(255)), 1'b0);
                     gen_pat.delete();
                  end else begin
                     b = pick_symbol();
                     add_item(CMD_APPEND, b, 1'b0);
                     if (gen_pat.size() < PAT_CAP) gen_pat = {gen_pat, b};
                  end
               end
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (req_queue.size() != 0 || req_tvalid || text_result_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = req_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_item.data_byte;
            req_tuser <= next_item.cmd;
            req_tlast <= next_item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off
   initial begin
      wait (hold_go);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            if (predict_transaction({spd_cmd_type'(req_tuser), req_tdata, req_tlast}, want))
               text_result_q = {text_result_q, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tdata[0];
            got.pattern_overflow = rsp_tdata[1];
            if (text_result_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result found=%0b overflow=%0b",
                                       got.found, got.pattern_overflow));
            end else begin
               want = text_result_q.pop_front();
               if (got.found !== want.found || got.pattern_overflow !== want.pattern_overflow)
                  note_mismatch($sformatf(
                     "mismatch: expected found=%0b overflow=%0b, got found=%0b overflow=%0b",
                     want.found, want.pattern_overflow, got.found, got.pattern_overflow));
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int k;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pattern with empty text, then with a one-byte text
      add_item(CMD_END, 8'hFF, 1'b1);
      add_item(CMD_TEXT, 8'h00, 1'b1);
      add_item(CMD_APPEND, 8'hFF, 1'b1);
      add_item(CMD_APPEND, 8'h00, 1'b0);
      // match followed by the separator byte
      add_item(CMD_TEXT, 8'hFF, 1'b0);
      add_item(CMD_TEXT, 8'h00, 1'b0);
      add_item(CMD_TEXT, SEPARATOR, 1'b1);
      // end command after text bytes
      add_item(CMD_TEXT, 8'h00, 1'b0);
      add_item(CMD_TEXT, 8'hFF, 1'b0);
      add_item(CMD_END, 8'h00, 1'b0);
      // append during a text abandons it
      add_item(CMD_TEXT, 8'hFF, 1'b0);
      add_item(CMD_APPEND, SEPARATOR, 1'b0);
      add_item(CMD_TEXT, 8'h00, 1'b0);
      add_item(CMD_TEXT, SEPARATOR, 1'b1);
      // fill to capacity, then overflow
      for (k = 0; k < 13; k++) add_item(CMD_APPEND, BYTE_W'(k * 19 + 3), 1'b0);
      add_item(CMD_APPEND, 8'h5A, 1'b0);
      add_item(CMD_TEXT, 8'hFF, 1'b1);
      add_item(CMD_END, 8'h00, 1'b0);
      add_item(CMD_CLEAR, 8'hFF, 1'b1);
      add_item(CMD_TEXT, 8'hAA, 1'b1);
      wait_drained();

      // no idling, with a long receiver hold-off while the sender keeps going
      build_random_traffic(ITEMS_PER_PHASE);
      hold_go = 1'b1;
      wait_drained();

      send_idle_pct = 79;
      recv_stall_pct = 0;
      build_random_traffic(ITEMS_PER_PHASE);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 79;
      build_random_traffic(ITEMS_PER_PHASE);
      wait_drained();

      send_idle_pct = 27;
      recv_stall_pct = 27;
      build_random_traffic(ITEMS_PER_PHASE);
      wait_drained();

      if (mismatch_count == 0 && text_result_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
